### rtl/core/psched_pkg.sv
// Shared types and constants of the periodic task scheduler.
`timescale 1ns / 1ps

package psched_pkg;

  localparam int TimeW        = 32;
  localparam int DueW         = 4;
  localparam int TaskCountW   = 3;
  localparam int TaskLimW     = 4;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;
  localparam int IntervalRegs = 4;

  localparam logic [CfgIdxW-1:0] CfgTaskCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInterval0 = 3'd1;

  localparam logic [TimeW-1:0] IntervalReset = 32'd1000;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_CHECK,
    PS_DIV,
    PS_FIN
  } ps_state_t;

  typedef struct packed {
    logic             start;
    logic [TimeW-1:0] dividend;
    logic [TimeW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] rem;
  } mod_rsp_t;

endpackage

### rtl/core/psched_if.sv
// Handshake interfaces for the time input and the due-mask result channels.
`timescale 1ns / 1ps

interface psched_in_if;
  logic                         valid;
  logic                         ready;
  logic [psched_pkg::TimeW-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface

interface psched_out_if;
  logic                        valid;
  logic                        ready;
  logic [psched_pkg::DueW-1:0] due_mask;
  logic                        evaluated;

  modport source (output valid, output due_mask, output evaluated, input ready);
  modport sink (input valid, input due_mask, input evaluated, output ready);
endinterface

### rtl/core/psched_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module psched_mod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psched_pkg::mod_req_t req,
  output psched_pkg::mod_rsp_t rsp
);

  localparam int W    = psched_pkg::TimeW;
  localparam int CntW = $clog2(W);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]    dvd_r, dvd_nxt;
  logic [W-1:0]    dvs_r, dvs_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [W:0]      trial;
  logic [W:0]      diff;

  always_comb begin
    trial    = {rem_r, dvd_r[W-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[W-1:0] : trial[W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### rtl/core/periodic_task_scheduler_core.sv
// Top level of the periodic task scheduler: task sequencer, state and result register.
`timescale 1ns / 1ps

// Each input transaction carries the current millisecond time. When scheduling is enabled and
// the time has changed, the tasks are checked one after another; when a task is due with a
// non-zero interval, its phase-keeping remainder is formed by a shared bit-serial divider
// that retires one dividend bit per cycle, and the sequencer waits for the remainder. The
// result register lets the next transaction enter while a result waits to be taken.
module periodic_task_scheduler_core #(
  parameter int TASK_SLOTS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  psched_in_if.sink                           in_if,
  psched_out_if.source                        out_if,
  input  logic                                cfg_we,
  input  logic [psched_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [psched_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int W    = psched_pkg::TimeW;
  localparam int IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LimW = psched_pkg::TaskLimW;
  localparam int DueW = psched_pkg::DueW;

  psched_pkg::ps_state_t state_r, state_nxt;

  logic [IdxW-1:0]                  idx_r, idx_nxt;
  logic [W-1:0]                     now_r, now_nxt;
  logic [TASK_SLOTS-1:0]            mask_r, mask_nxt;
  logic                             eval_r, eval_nxt;
  logic [W-1:0]                     last_eval_r, last_eval_nxt;
  logic [W-1:0]                     last_run_r [TASK_SLOTS];
  logic [W-1:0]                     last_run_nxt [TASK_SLOTS];
  logic [W-1:0]                     interval_r [TASK_SLOTS];
  logic [W-1:0]                     interval_nxt [TASK_SLOTS];
  logic [psched_pkg::TaskCountW-1:0] task_count_r, task_count_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [DueW-1:0]                  out_mask_r, out_mask_nxt;
  logic                             out_eval_r, out_eval_nxt;

  logic [W-1:0]                  elapsed;
  logic [W-1:0]                  period;
  logic [LimW-1:0]               count_ext;
  logic [LimW-1:0]               lim;
  logic                          is_last;
  logic [TASK_SLOTS+DueW-1:0]    mask_ext;
  psched_pkg::mod_req_t          mod_req;
  psched_pkg::mod_rsp_t          mod_rsp;

  psched_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  always_comb begin
    elapsed   = now_r - last_run_r[idx_r];
    period    = interval_r[idx_r];
    count_ext = LimW'(task_count_r);
    lim       = (count_ext > LimW'(TASK_SLOTS)) ? LimW'(TASK_SLOTS) : count_ext;
    is_last   = (LimW'(idx_r) + 1'b1) == lim;
    mask_ext  = {{DueW{1'b0}}, mask_r};

    state_nxt      = state_r;
    idx_nxt        = idx_r;
    now_nxt        = now_r;
    mask_nxt       = mask_r;
    eval_nxt       = eval_r;
    last_eval_nxt  = last_eval_r;
    last_run_nxt   = last_run_r;
    interval_nxt   = interval_r;
    task_count_nxt = task_count_r;
    out_valid_nxt  = out_valid_r;
    out_mask_nxt   = out_mask_r;
    out_eval_nxt   = out_eval_r;
    in_if.ready    = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = elapsed;
    mod_req.divisor  = period;

    if (cfg_we) begin
      if (cfg_index == psched_pkg::CfgTaskCount) begin
        task_count_nxt = cfg_data[psched_pkg::TaskCountW-1:0];
      end
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (i < psched_pkg::IntervalRegs &&
            cfg_index == psched_pkg::CfgInterval0 + psched_pkg::CfgIdxW'(i)) begin
          interval_nxt[i] = cfg_data[W-1:0];
        end
      end
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      psched_pkg::PS_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          now_nxt  = in_if.now_ms;
          mask_nxt = '0;
          idx_nxt  = '0;
          if (lim != '0 && in_if.now_ms != last_eval_r) begin
            eval_nxt  = 1'b1;
            state_nxt = psched_pkg::PS_CHECK;
          end else begin
            eval_nxt  = 1'b0;
            state_nxt = psched_pkg::PS_FIN;
          end
        end
      end
      psched_pkg::PS_CHECK: begin
        if (elapsed >= period) begin
          mask_nxt[idx_r] = 1'b1;
        end
        if (elapsed >= period && period != '0) begin
          mod_req.start = 1'b1;
          state_nxt     = psched_pkg::PS_DIV;
        end else begin
          if (elapsed >= period) begin
            last_run_nxt[idx_r] = now_r;
          end
          if (is_last) begin
            last_eval_nxt = now_r;
            state_nxt     = psched_pkg::PS_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      psched_pkg::PS_DIV: begin
        if (mod_rsp.done) begin
          last_run_nxt[idx_r] = now_r - mod_rsp.rem;
          if (is_last) begin
            last_eval_nxt = now_r;
            state_nxt     = psched_pkg::PS_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = psched_pkg::PS_CHECK;
          end
        end
      end
      psched_pkg::PS_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = mask_ext[DueW-1:0];
          out_eval_nxt  = eval_r;
          state_nxt     = psched_pkg::PS_IDLE;
        end
      end
      default: begin
        state_nxt = psched_pkg::PS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psched_pkg::PS_IDLE;
      last_eval_r  <= '0;
      task_count_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        last_run_r[i] <= '0;
        interval_r[i] <= psched_pkg::IntervalReset;
      end
    end else begin
      state_r      <= state_nxt;
      last_eval_r  <= last_eval_nxt;
      task_count_r <= task_count_nxt;
      out_valid_r  <= out_valid_nxt;
      last_run_r   <= last_run_nxt;
      interval_r   <= interval_nxt;
    end
    idx_r      <= idx_nxt;
    now_r      <= now_nxt;
    mask_r     <= mask_nxt;
    eval_r     <= eval_nxt;
    out_mask_r <= out_mask_nxt;
    out_eval_r <= out_eval_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.due_mask  = out_mask_r;
  assign out_if.evaluated = out_eval_r;

endmodule

### verif/testbench.sv
// Self-checking testbench of the periodic task scheduler core.
`timescale 1ns / 1ps

localparam int NumTasks = 4;

typedef struct packed {
  logic [psched_pkg::DueW-1:0] due_mask;
  logic                        evaluated;
} tick_outcome_t;

class sched_scoreboard;
  logic [psched_pkg::TaskCountW-1:0] task_count;
  logic [psched_pkg::TimeW-1:0]      intervals [NumTasks];
  logic [psched_pkg::TimeW-1:0]      last_run [NumTasks];
  logic [psched_pkg::TimeW-1:0]      last_eval;
  tick_outcome_t                     tick_outcomes [$];
  int                                errors;

  function new();
    task_count = '0;
    last_eval  = '0;
    errors     = 0;
    for (int i = 0; i < NumTasks; i++) begin
      intervals[i] = psched_pkg::IntervalReset;
      last_run[i]  = '0;
    end
  endfunction

  function void write_reg(logic [psched_pkg::CfgIdxW-1:0] idx,
                          logic [psched_pkg::CfgDataW-1:0] data);
    int slot;
    slot = int'(idx) - int'(psched_pkg::CfgInterval0);
    if (idx == psched_pkg::CfgTaskCount) begin
      task_count = data[psched_pkg::TaskCountW-1:0];
    end else if (slot >= 0 && slot < psched_pkg::IntervalRegs && slot < NumTasks) begin
      intervals[slot] = data[psched_pkg::TimeW-1:0];
    end
  endfunction

  // Works out the due mask of one accepted time transaction and advances the task phases.
  function void schedule_tick(logic [psched_pkg::TimeW-1:0] now);
    int                           active;
    logic [psched_pkg::TimeW-1:0] elapsed;
    logic [psched_pkg::TimeW-1:0] period;
    tick_outcome_t                outcome;
    active  = (int'(task_count) > NumTasks) ? NumTasks : int'(task_count);
    outcome = '0;
    if (active != 0 && now != last_eval) begin
      outcome.evaluated = 1'b1;
      for (int i = 0; i < active; i++) begin
        elapsed = now - last_run[i];
        period  = intervals[i];
        if (elapsed >= period) begin
          if (i < psched_pkg::DueW) outcome.due_mask[i] = 1'b1;
          last_run[i] = (period == '0) ? now : now - (elapsed % period);
        end
      end
      last_eval = now;
    end
    tick_outcomes.push_back(outcome);
  endfunction

  function void report(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
  endfunction

  function void check_result(logic [psched_pkg::DueW-1:0] due_mask, logic evaluated);
    tick_outcome_t want;
    if (tick_outcomes.size() == 0) begin
      errors++;
      $display("%0t: result with nothing outstanding: due_mask %0h, evaluated %0d",
               $time, due_mask, evaluated);
      return;
    end
    want = tick_outcomes.pop_front();
    if (want.due_mask !== due_mask) report("due_mask", 32'(want.due_mask), 32'(due_mask));
    if (want.evaluated !== evaluated) report("evaluated", 32'(want.evaluated), 32'(evaluated));
  endfunction
endclass

module testbench;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [psched_pkg::CfgIdxW-1:0]  cfg_index;
  logic [psched_pkg::CfgDataW-1:0] cfg_data;
  bit                              idle_on = 1'b1;

  psched_in_if  in_ch ();
  psched_out_if out_ch ();

  sched_scoreboard sb = new();

  periodic_task_scheduler_core #(
    .TASK_SLOTS (NumTasks)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [psched_pkg::TimeW-1:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 60) return $urandom_range(1, 16);
    if (r < 80) return $urandom_range(17, 2000);
    if (r < 92) return $urandom;
    return '1;
  endfunction

  function automatic logic [psched_pkg::TimeW-1:0] next_time(
      logic [psched_pkg::TimeW-1:0] cur);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return cur;
    if (r < 75) return cur + 1;
    if (r < 92) return cur + $urandom_range(2, 40);
    if (r < 97) return cur + $urandom_range(41, 3000);
    return $urandom;
  endfunction

  task automatic write_reg(input logic [psched_pkg::CfgIdxW-1:0] idx,
                           input logic [psched_pkg::CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_tick(input logic [psched_pkg::TimeW-1:0] now);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid  = 1'b0;
      in_ch.now_ms = $urandom;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.now_ms = now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.schedule_tick(now);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.tick_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.due_mask, out_ch.evaluated);
    end
  end

  initial begin
    logic [psched_pkg::TimeW-1:0]      cur_time;
    logic [psched_pkg::TimeW-1:0]      period;
    logic [psched_pkg::TaskCountW-1:0] count;
    int                                random_sent;
    int                                phase;
    int                                r;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = psched_pkg::CfgTaskCount;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.now_ms = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Scheduling disabled after reset.
    send_tick(32'd0);
    send_tick(32'd7);
    wait_idle();

    // Writes to unknown register indexes must leave the state alone.
    for (int k = 0; k < 3; k++) begin
      write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) +
                                     psched_pkg::IntervalRegs + k), $urandom);
    end
    write_reg(psched_pkg::CfgTaskCount, 32'hFFFF_FFF8 | 32'd4);
    write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) + 0), 32'd0);
    write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) + 1), 32'd1);
    write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) + 2), 32'hFFFF_FFFF);
    write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) + 3), 32'd3);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd1);
    send_tick(32'd2);
    send_tick(32'd3);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h8000_0000);
    send_tick(32'h8000_0001);
    send_tick(32'd0);
    wait_idle();

    // A task count above the number of tasks acts as the full set.
    write_reg(psched_pkg::CfgTaskCount, 32'd7);
    write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) + 0),
              psched_pkg::IntervalReset);
    write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) + 1), 32'd7);
    write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) + 3), 32'd2);
    send_tick(32'd1000);
    send_tick(32'd1001);
    send_tick(32'd1500);
    send_tick(32'd2000);
    send_tick(32'd0);
    wait_idle();
    write_reg(psched_pkg::CfgTaskCount, 32'd1);
    send_tick(32'd2001);
    send_tick(32'd2100);
    cur_time = 32'd2100;

    random_sent = 0;
    phase       = 0;
    while (random_sent < 800) begin
      wait_idle();
      idle_on = (phase != 0);
      r = $urandom_range(0, 99);
      if (r < 10) count = '0;
      else if (r < 85) count = psched_pkg::TaskCountW'($urandom_range(1, 4));
      else count = psched_pkg::TaskCountW'($urandom_range(5, 7));
      if (phase == 1 || phase == 2) count = psched_pkg::TaskCountW'(NumTasks);
      for (int i = 0; i < psched_pkg::IntervalRegs; i++) begin
        if (phase == 1) period = '0;
        else if (phase == 2) period = '1;
        else period = pick_interval();
        write_reg(psched_pkg::CfgIdxW'(int'(psched_pkg::CfgInterval0) + i), period);
      end
      write_reg(psched_pkg::CfgTaskCount,
                ($urandom << psched_pkg::TaskCountW) | psched_pkg::CfgDataW'(count));
      if ($urandom_range(0, 4) == 0) cur_time = 32'hFFFF_FFFF - $urandom_range(0, 100);
      repeat ($urandom_range(40, 100)) begin
        cur_time = next_time(cur_time);
        send_tick(cur_time);
        random_sent++;
      end
      phase++;
    end

    in_ch.valid = 1'b0;
    while (sb.tick_outcomes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/psched_pkg.sv
rtl/core/psched_if.sv
rtl/core/psched_mod.sv
rtl/core/periodic_task_scheduler_core.sv
verif/testbench.sv
